// ----- design/rit_pkg.sv -----
// Shared types, constants and helpers for the reference-counted object table.
// No dependencies; the controller and the top level refer to it by scoped names.
package rit_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = SLOT_W + 1;
    localparam int DATA_W  = 16;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    // action codes
    localparam logic [2:0] ACT_GET      = 3'd0;
    localparam logic [2:0] ACT_PUT      = 3'd1;
    localparam logic [2:0] ACT_CLR_ALL  = 3'd2;
    localparam logic [2:0] ACT_SET_ALL  = 3'd3;
    localparam logic [2:0] ACT_SET_SLOT = 3'd4;
    localparam logic [2:0] ACT_CLR_SLOT = 3'd5;

    // status codes
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_MISS      = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_HELD      = 3'd3;
    localparam logic [2:0] ST_RELEASED  = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;
    localparam logic [2:0] ST_SATURATED = 3'd7;

    // one memory port request from the controller
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
    } rit_mem_req_t;

    function automatic logic slot_ok(input logic [5:0] s);
        logic [31:0] w;
        w = 32'(s);
        return (w < 32'(SLOTS));
    endfunction

    function automatic logic [SLOT_W-1:0] slot_to_idx(input logic [5:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SLOT_W-1:0];
    endfunction

    // low 6 bits of a table index, as carried in the result word
    function automatic logic [5:0] idx_to_field(input logic [SLOT_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[5:0];
    endfunction

endpackage

// ----- design/rit_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; used by the controller and the top level.
interface rit_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] object_number;
    logic [5:0]  slot;

    modport source (output valid, action, object_number, slot, input ready);
    modport sink   (input valid, action, object_number, slot, output ready);
endinterface

interface rit_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic        need_load;
    logic        need_writeback;
    logic [15:0] entry_number;
    logic [15:0] ref_count_out;

    modport source (output valid, status, slot_index, need_load, need_writeback,
                    entry_number, ref_count_out, input ready);
    modport sink   (input valid, status, slot_index, need_load, need_writeback,
                    entry_number, ref_count_out, output ready);
endinterface

// ----- design/rit_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rit_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                                      clk,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rit_ctrl.sv -----
// Sequencer: reset clear pass, get scan, slot read-modify-write, count sweep.
// Depends on rit_pkg and rit_if; drives the count and number memories.
module rit_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    rit_req_if.sink                     req,
    rit_rsp_if.source                   rsp,
    output rit_pkg::rit_mem_req_t       cnt_mem,
    output rit_pkg::rit_mem_req_t       num_mem,
    input  logic [rit_pkg::DATA_W-1:0]  cnt_rdata,
    input  logic [rit_pkg::DATA_W-1:0]  num_rdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SLOT,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]                 status;
        logic [5:0]                 slot_index;
        logic                       need_load;
        logic                       need_writeback;
        logic [rit_pkg::DATA_W-1:0] entry_number;
        logic [rit_pkg::DATA_W-1:0] ref_count_out;
    } result_t;

    localparam logic [rit_pkg::CNT_W-1:0] CNT_END  = rit_pkg::CNT_W'(rit_pkg::SLOTS);
    localparam logic [rit_pkg::CNT_W-1:0] CNT_LAST = rit_pkg::CNT_W'(rit_pkg::SLOTS - 1);
    localparam logic [rit_pkg::DATA_W-1:0] ONE     = rit_pkg::DATA_W'(1);

    state_t                      state_reg,    state_next;
    logic [rit_pkg::CNT_W-1:0]   cnt_reg,      cnt_next;
    logic                        rd_vld_reg,   rd_vld_next;
    logic [rit_pkg::SLOT_W-1:0]  rd_idx_reg,   rd_idx_next;
    logic                        free_vld_reg, free_vld_next;
    logic [rit_pkg::SLOT_W-1:0]  free_idx_reg, free_idx_next;
    logic [2:0]                  act_reg,      act_next;
    logic [rit_pkg::DATA_W-1:0]  onum_reg,     onum_next;
    logic [5:0]                  slot_reg,     slot_next;
    result_t                     res_reg,      res_next;
    result_t                     out_reg,      out_next;
    logic                        out_vld_reg,  out_vld_next;

    logic [rit_pkg::SLOT_W-1:0]  slot_idx;
    logic [rit_pkg::SLOT_W-1:0]  scan_idx;
    logic [rit_pkg::DATA_W-1:0]  cnt_dec;
    logic [rit_pkg::DATA_W-1:0]  sweep_val;

    assign slot_idx  = rit_pkg::slot_to_idx(slot_reg);
    assign scan_idx  = cnt_reg[rit_pkg::SLOT_W-1:0];
    assign cnt_dec   = cnt_rdata - ONE;
    assign sweep_val = (act_reg == rit_pkg::ACT_SET_ALL) ? ONE : '0;

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_vld_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.slot_index     = out_reg.slot_index;
    assign rsp.need_load      = out_reg.need_load;
    assign rsp.need_writeback = out_reg.need_writeback;
    assign rsp.entry_number   = out_reg.entry_number;
    assign rsp.ref_count_out  = out_reg.ref_count_out;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        free_vld_next = free_vld_reg;
        free_idx_next = free_idx_reg;
        act_next      = act_reg;
        onum_next     = onum_reg;
        slot_next     = slot_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg & ~rsp.ready;
        cnt_mem       = '0;
        num_mem       = '0;

        case (state_reg)
            S_INIT:
            begin
                // clear pass: zero one entry of both memories per cycle
                cnt_mem.we    = 1'b1;
                cnt_mem.waddr = scan_idx;
                num_mem.we    = 1'b1;
                num_mem.waddr = scan_idx;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next  = req.action;
                    onum_next = req.object_number;
                    slot_next = req.slot;
                    res_next  = '0;
                    case (req.action)
                        rit_pkg::ACT_GET:
                        begin
                            cnt_next      = '0;
                            free_vld_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                        rit_pkg::ACT_PUT, rit_pkg::ACT_SET_SLOT, rit_pkg::ACT_CLR_SLOT:
                        begin
                            if (rit_pkg::slot_ok(req.slot))
                            begin
                                cnt_mem.re    = 1'b1;
                                cnt_mem.raddr = rit_pkg::slot_to_idx(req.slot);
                                num_mem.re    = 1'b1;
                                num_mem.raddr = rit_pkg::slot_to_idx(req.slot);
                                state_next    = S_SLOT;
                            end
                            else
                            begin
                                res_next.status     = (req.action == rit_pkg::ACT_PUT) ?
                                                      rit_pkg::ST_IGNORED : rit_pkg::ST_DONE;
                                res_next.slot_index = req.slot;
                                state_next          = S_DONE;
                            end
                        end
                        rit_pkg::ACT_CLR_ALL, rit_pkg::ACT_SET_ALL:
                        begin
                            // fetch slot 0's number now; the sweep leaves it alone
                            num_mem.re    = 1'b1;
                            num_mem.raddr = '0;
                            cnt_next      = '0;
                            state_next    = S_SWEEP;
                        end
                        default:
                        begin
                            res_next.status = rit_pkg::ST_DONE;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle; examine the word read last cycle
                if (cnt_reg < CNT_END)
                begin
                    cnt_mem.re    = 1'b1;
                    cnt_mem.raddr = scan_idx;
                    num_mem.re    = 1'b1;
                    num_mem.raddr = scan_idx;
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx;
                    cnt_next      = cnt_reg + 1'b1;
                end

                if (rd_vld_reg)
                begin
                    if ((cnt_rdata != '0) && (num_rdata == onum_reg))
                    begin
                        res_next.slot_index   = rit_pkg::idx_to_field(rd_idx_reg);
                        res_next.entry_number = num_rdata;
                        if (cnt_rdata == rit_pkg::COUNT_MAX)
                        begin
                            res_next.status        = rit_pkg::ST_SATURATED;
                            res_next.ref_count_out = cnt_rdata;
                        end
                        else
                        begin
                            cnt_mem.we             = 1'b1;
                            cnt_mem.waddr          = rd_idx_reg;
                            cnt_mem.wdata          = cnt_rdata + ONE;
                            res_next.status        = rit_pkg::ST_HIT;
                            res_next.ref_count_out = cnt_rdata + ONE;
                        end
                        state_next = S_DONE;
                    end
                    else if ((cnt_rdata == '0) && !free_vld_reg)
                    begin
                        free_vld_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                else if (cnt_reg == CNT_END)
                begin
                    if (free_vld_reg)
                    begin
                        cnt_mem.we             = 1'b1;
                        cnt_mem.waddr          = free_idx_reg;
                        cnt_mem.wdata          = ONE;
                        num_mem.we             = 1'b1;
                        num_mem.waddr          = free_idx_reg;
                        num_mem.wdata          = onum_reg;
                        res_next.status        = rit_pkg::ST_MISS;
                        res_next.slot_index    = rit_pkg::idx_to_field(free_idx_reg);
                        res_next.need_load     = 1'b1;
                        res_next.entry_number  = onum_reg;
                        res_next.ref_count_out = ONE;
                    end
                    else
                    begin
                        res_next.status = rit_pkg::ST_FULL;
                    end
                    state_next = S_DONE;
                end
            end

            S_SLOT:
            begin
                res_next.slot_index   = slot_reg;
                res_next.entry_number = num_rdata;
                cnt_mem.waddr         = slot_idx;
                case (act_reg)
                    rit_pkg::ACT_PUT:
                    begin
                        if (cnt_rdata == '0)
                        begin
                            res_next.status        = rit_pkg::ST_IGNORED;
                            res_next.ref_count_out = '0;
                        end
                        else
                        begin
                            cnt_mem.we             = 1'b1;
                            cnt_mem.wdata          = cnt_dec;
                            res_next.ref_count_out = cnt_dec;
                            if (cnt_dec == '0)
                            begin
                                res_next.status         = rit_pkg::ST_RELEASED;
                                res_next.need_writeback = 1'b1;
                            end
                            else
                            begin
                                res_next.status = rit_pkg::ST_HELD;
                            end
                        end
                    end
                    rit_pkg::ACT_SET_SLOT:
                    begin
                        cnt_mem.we             = 1'b1;
                        cnt_mem.wdata          = ONE;
                        res_next.status        = rit_pkg::ST_DONE;
                        res_next.ref_count_out = ONE;
                    end
                    default:
                    begin
                        cnt_mem.we             = 1'b1;
                        cnt_mem.wdata          = '0;
                        res_next.status        = rit_pkg::ST_DONE;
                        res_next.ref_count_out = '0;
                    end
                endcase
                state_next = S_DONE;
            end

            S_SWEEP:
            begin
                cnt_mem.we    = 1'b1;
                cnt_mem.waddr = scan_idx;
                cnt_mem.wdata = sweep_val;
                if (cnt_reg == CNT_LAST)
                begin
                    res_next.status        = rit_pkg::ST_DONE;
                    res_next.entry_number  = num_rdata;
                    res_next.ref_count_out = sweep_val;
                    state_next             = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            free_vld_reg <= 1'b0;
            free_idx_reg <= '0;
            act_reg      <= '0;
            onum_reg     <= '0;
            slot_reg     <= '0;
            res_reg      <= '0;
            out_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            rd_idx_reg   <= rd_idx_next;
            free_vld_reg <= free_vld_next;
            free_idx_reg <= free_idx_next;
            act_reg      <= act_next;
            onum_reg     <= onum_next;
            slot_reg     <= slot_next;
            res_reg      <= res_next;
            out_reg      <= out_next;
            out_vld_reg  <= out_vld_next;
        end
    end

endmodule

// ----- design/refcounted_inode_table_top.sv -----
// Top level of the reference-counted object table.
// Depends on rit_pkg, rit_if, rit_ram and rit_ctrl.
//
// Table of SLOTS (64) open-object slots, each an object number plus a 16-bit
// reference count, held in two synchronous RAMs (counts, numbers) with
// registered read data. The block takes one request word at a time. After
// reset it runs a clearing pass over all SLOTS (64) entries, zeroing both
// RAMs, and holds req.ready low until done. A get streams the table through
// the RAM read ports, one slot per cycle, and stops at the first active slot
// holding the number; otherwise it claims the lowest free slot. Put, set slot
// and clear slot are one read-modify-write. Clear all and set all sweep the
// count RAM one entry per cycle. Requests with an out-of-range slot or an
// unused action go to the result without a memory access. The response sits
// in an output register, so the next request is accepted while a response
// waits; a finished request waits in turn until the output register is free.
// Counts saturate at 65535 (status saturated, count kept). The caller issues
// the actual load or writeback when need_load or need_writeback is set.
module refcounted_inode_table_top (
    input  logic      clk,
    input  logic      rst_n,
    rit_req_if.sink   req,
    rit_rsp_if.source rsp
);

    rit_pkg::rit_mem_req_t        cnt_mem;
    rit_pkg::rit_mem_req_t        num_mem;
    logic [rit_pkg::DATA_W-1:0]   cnt_rdata;
    logic [rit_pkg::DATA_W-1:0]   num_rdata;

    // sequencer: all decisions, result formatting and output register
    rit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cnt_mem   (cnt_mem),
        .num_mem   (num_mem),
        .cnt_rdata (cnt_rdata),
        .num_rdata (num_rdata)
    );

    // reference counts
    rit_ram #(
        .DEPTH (rit_pkg::SLOTS),
        .WIDTH (rit_pkg::DATA_W)
    ) u_cnt_ram (
        .clk   (clk),
        .re    (cnt_mem.re),
        .raddr (cnt_mem.raddr),
        .rdata (cnt_rdata),
        .we    (cnt_mem.we),
        .waddr (cnt_mem.waddr),
        .wdata (cnt_mem.wdata)
    );

    // object numbers; only the reset pass and a claiming get write here
    rit_ram #(
        .DEPTH (rit_pkg::SLOTS),
        .WIDTH (rit_pkg::DATA_W)
    ) u_num_ram (
        .clk   (clk),
        .re    (num_mem.re),
        .raddr (num_mem.raddr),
        .rdata (num_rdata),
        .we    (num_mem.we),
        .waddr (num_mem.waddr),
        .wdata (num_mem.wdata)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for refcounted_inode_table_top: drives get/put/table words
// and checks every response word against an in-bench model of the slot table.
// Depends on rit_pkg, rit_if (rit_req_if, rit_rsp_if) and the design sources.
module testbench;

    // action codes the block treats as no-ops
    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    // Slowest correct run: ~600 words. The limit covers every word at the full
    // scan plus the longest idle gap and the longest response stall.
    localparam int CYCLE_LIMIT  = 500_000;
    // quiet time after the last response; a stray response word in it is flagged
    localparam int DRAIN_CYCLES = rit_pkg::SLOTS + 8;
    localparam int RANDOM_WORDS = 380;
    localparam int POOL_SIZE    = 20;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic        need_load;
        logic        need_writeback;
        logic [15:0] entry_number;
        logic [15:0] ref_count_out;
    } table_result_t;

    logic clk;
    logic rst_n;

    rit_req_if req_ch ();
    rit_rsp_if rsp_ch ();

    refcounted_inode_table_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model copy of the table
    logic [15:0] model_count  [rit_pkg::SLOTS];
    logic [15:0] model_number [rit_pkg::SLOTS];

    // responses still owed by the block, oldest first
    table_result_t pending_results [$];
    table_result_t want_word;

    int error_count   = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int cycle_count   = 0;
    int stall_left    = 0;
    int status_seen [8];
    bit idle_enable   = 1'b1;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    // fill the slot-related fields from the model after the update
    function automatic void report_slot(inout table_result_t r, input int idx);
        r.slot_index    = 6'(idx);
        r.entry_number  = model_number[idx];
        r.ref_count_out = model_count[idx];
    endfunction

    // apply one request word to the model, return the response it owes
    function automatic table_result_t predict_table_step(input logic [2:0] act,
                                                         input logic [15:0] num,
                                                         input logic [5:0] s);
        table_result_t r;
        int hit_idx;
        int free_idx;
        int sl;
        r        = '0;
        sl       = int'(s);
        hit_idx  = -1;
        free_idx = -1;
        case (act)
            rit_pkg::ACT_GET:
            begin
                // first active slot with the number wins, else lowest free slot
                for (int i = 0; i < rit_pkg::SLOTS; i++)
                begin
                    if (hit_idx < 0 && model_count[i] != 16'd0 && model_number[i] == num)
                        hit_idx = i;
                    if (free_idx < 0 && model_count[i] == 16'd0)
                        free_idx = i;
                end
                if (hit_idx >= 0)
                begin
                    if (model_count[hit_idx] == rit_pkg::COUNT_MAX)
                        r.status = rit_pkg::ST_SATURATED;
                    else
                    begin
                        model_count[hit_idx] = model_count[hit_idx] + 16'd1;
                        r.status = rit_pkg::ST_HIT;
                    end
                    report_slot(r, hit_idx);
                end
                else if (free_idx >= 0)
                begin
                    model_count[free_idx]  = 16'd1;
                    model_number[free_idx] = num;
                    r.status    = rit_pkg::ST_MISS;
                    r.need_load = 1'b1;
                    report_slot(r, free_idx);
                end
                else
                    r.status = rit_pkg::ST_FULL;
            end
            rit_pkg::ACT_PUT:
            begin
                r.status = rit_pkg::ST_IGNORED;
                if (sl >= rit_pkg::SLOTS)
                    r.slot_index = s;
                else
                begin
                    if (model_count[sl] != 16'd0)
                    begin
                        model_count[sl] = model_count[sl] - 16'd1;
                        r.need_writeback = (model_count[sl] == 16'd0);
                        r.status = r.need_writeback ? rit_pkg::ST_RELEASED
                                                    : rit_pkg::ST_HELD;
                    end
                    report_slot(r, sl);
                end
            end
            rit_pkg::ACT_CLR_ALL, rit_pkg::ACT_SET_ALL:
            begin
                for (int i = 0; i < rit_pkg::SLOTS; i++)
                    model_count[i] = (act == rit_pkg::ACT_SET_ALL) ? 16'd1 : 16'd0;
                r.status = rit_pkg::ST_DONE;
                report_slot(r, 0);
            end
            rit_pkg::ACT_SET_SLOT, rit_pkg::ACT_CLR_SLOT:
            begin
                r.status = rit_pkg::ST_DONE;
                if (sl >= rit_pkg::SLOTS)
                    r.slot_index = s;
                else
                begin
                    model_count[sl] = (act == rit_pkg::ACT_SET_SLOT) ? 16'd1 : 16'd0;
                    report_slot(r, sl);
                end
            end
            default:
                r.status = rit_pkg::ST_DONE;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one word and hold it until accepted. Valid is left high after
    // acceptance; it is lowered only for a random idle gap before the next word
    // (while idle_enable is set) and by wait_drained.
    task automatic send_word(input logic [2:0] act, input logic [15:0] num,
                             input logic [5:0] s);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.object_number <= num;
        req_ch.slot          <= s;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(predict_table_step(act, num, s));
        words_sent++;
    endtask

    // park the request side until every owed response is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall bursts while enabled
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("MISMATCH at response %0d, %s: got 0x%0h, want 0x%0h",
                 words_checked, what, got, want);
    endtask

    // every accepted response word is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            words_checked++;
            status_seen[rsp_ch.status]++;
            if (pending_results.size() == 0)
                report_mismatch("word with nothing pending, status", rsp_ch.status, 0);
            else
            begin
                want_word = pending_results.pop_front();
                if (rsp_ch.status !== want_word.status)
                    report_mismatch("status", rsp_ch.status, want_word.status);
                if (rsp_ch.slot_index !== want_word.slot_index)
                    report_mismatch("slot_index", rsp_ch.slot_index, want_word.slot_index);
                if (rsp_ch.need_load !== want_word.need_load)
                    report_mismatch("need_load", rsp_ch.need_load, want_word.need_load);
                if (rsp_ch.need_writeback !== want_word.need_writeback)
                    report_mismatch("need_writeback", rsp_ch.need_writeback,
                                    want_word.need_writeback);
                if (rsp_ch.entry_number !== want_word.entry_number)
                    report_mismatch("entry_number", rsp_ch.entry_number,
                                    want_word.entry_number);
                if (rsp_ch.ref_count_out !== want_word.ref_count_out)
                    report_mismatch("ref_count_out", rsp_ch.ref_count_out,
                                    want_word.ref_count_out);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses owed",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every action once, field extremes, hit/miss/held/released/ignored,
    // full table after set all, unused action codes
    task automatic test_directed_ops();
        send_word(rit_pkg::ACT_GET, 16'h0000, 6'h00);     // miss, claims slot 0
        send_word(rit_pkg::ACT_GET, 16'hFFFF, 6'h3F);     // miss, claims slot 1
        send_word(rit_pkg::ACT_GET, 16'h0000, 6'h00);     // hit slot 0
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'h00);     // held
        send_word(rit_pkg::ACT_PUT, 16'hFFFF, 6'h00);     // released, writeback
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'h00);     // count already zero: ignored
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'h3F);     // never used slot: ignored
        send_word(rit_pkg::ACT_SET_SLOT, 16'h0000, 6'h3F);
        send_word(rit_pkg::ACT_GET, 16'h0000, 6'h00);     // stale number in slot 63 now hits
        send_word(rit_pkg::ACT_CLR_SLOT, 16'hFFFF, 6'h3F);
        send_word(ACT_SPARE6, 16'hFFFF, 6'h3F);
        send_word(ACT_SPARE7, 16'hFFFF, 6'h3F);
        send_word(rit_pkg::ACT_SET_ALL, 16'h0000, 6'h00); // every slot busy
        send_word(rit_pkg::ACT_GET, 16'h1234, 6'h00);     // no match, no free slot: full
        send_word(rit_pkg::ACT_GET, 16'hFFFF, 6'h00);     // slot 1 still holds FFFF
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'h01);
        send_word(rit_pkg::ACT_CLR_ALL, 16'hFFFF, 6'h3F);
        send_word(rit_pkg::ACT_GET, 16'hFFFF, 6'h00);
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'h00);
    endtask

    // fill all slots with distinct numbers, then full, hit, release, reclaim
    task automatic test_table_full();
        send_word(rit_pkg::ACT_CLR_ALL, 16'h0000, 6'h00);
        for (int i = 0; i < rit_pkg::SLOTS; i++)
            send_word(rit_pkg::ACT_GET, 16'h8000 + 16'(i * 37), 6'(i));
        // hold the request side until the table has answered everything
        wait_drained();
        send_word(rit_pkg::ACT_GET, 16'h7777, 6'h00);
        send_word(rit_pkg::ACT_GET, 16'h8000 + 16'(5 * 37), 6'h00);
        send_word(rit_pkg::ACT_PUT, 16'h0000, 6'd37);
        send_word(rit_pkg::ACT_GET, 16'h7777, 6'h00);     // takes the slot just freed
        send_word(rit_pkg::ACT_CLR_ALL, 16'h0000, 6'h00);
    endtask

    // Mostly gets from a small number pool and puts on live slots, so the
    // table keeps hitting, filling and releasing; the rest is noise.
    task automatic test_random_traffic();
        logic [15:0] number_pool [POOL_SIZE];
        int active_slots [$];
        int pick;
        number_pool[0] = 16'h0000;
        number_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            number_pool[i] = 16'($urandom);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // a quiet stretch mid-run and none in the last part
            idle_enable = !(n >= 200 && n < 260) && (n < RANDOM_WORDS - 90);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_word(rit_pkg::ACT_GET,
                          number_pool[$urandom_range(0, POOL_SIZE - 1)], 6'($urandom));
            else if (pick < 48)
                send_word(rit_pkg::ACT_GET, 16'($urandom), 6'($urandom));
            else if (pick < 78)
            begin
                active_slots.delete();
                for (int i = 0; i < rit_pkg::SLOTS; i++)
                    if (model_count[i] != 16'd0)
                        active_slots.push_back(i);
                if (active_slots.size() != 0 && $urandom_range(0, 4) != 0)
                    send_word(rit_pkg::ACT_PUT, 16'($urandom),
                              6'(active_slots[$urandom_range(0, active_slots.size() - 1)]));
                else
                    send_word(rit_pkg::ACT_PUT, 16'($urandom), 6'($urandom));
            end
            else if (pick < 84)
                send_word(rit_pkg::ACT_SET_SLOT, 16'($urandom), 6'($urandom));
            else if (pick < 90)
                send_word(rit_pkg::ACT_CLR_SLOT, 16'($urandom), 6'($urandom));
            else if (pick < 92)
                send_word(rit_pkg::ACT_CLR_ALL, 16'($urandom), 6'($urandom));
            else if (pick < 94)
                send_word(rit_pkg::ACT_SET_ALL, 16'($urandom), 6'($urandom));
            else if (pick < 97)
                send_word($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7,
                          16'($urandom), 6'($urandom));
            else
            begin
                // burst of fresh numbers to push the table toward full
                repeat (8)
                    send_word(rit_pkg::ACT_GET, 16'($urandom), 6'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = rit_pkg::ACT_GET;
        req_ch.object_number = 16'h0000;
        req_ch.slot          = 6'h00;
        foreach (status_seen[i])
            status_seen[i] = 0;
        for (int i = 0; i < rit_pkg::SLOTS; i++)
        begin
            model_count[i]  = 16'd0;
            model_number[i] = 16'd0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // the block's clearing pass shows up as ready held low
        test_directed_ops();
        test_table_full();
        test_random_traffic();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("responses never delivered", 0, pending_results.size());

        $display("Covered %0d request words (all actions, full table and reclaim,",
                 words_sent);
        $display("  random get/put mix): %0d responses checked; hit %0d miss %0d full %0d sat %0d",
                 words_checked, status_seen[rit_pkg::ST_HIT], status_seen[rit_pkg::ST_MISS],
                 status_seen[rit_pkg::ST_FULL], status_seen[rit_pkg::ST_SATURATED]);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
